FILE: hdl/assert_macros.svh
// Assertion helper macros for the RTL modules.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is high.
`define ASSERT_AT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/spm_pkg.sv
// Types, constants, decay ROMs and the per-channel update for the stereo peak meter.
// No dependencies.
`default_nettype none

package spm_pkg;

   localparam int AMP_BITS    = 16;
   localparam int MAX_STEP_MS = 100;
   localparam int FACT_BITS   = 16;
   localparam int HOLD_BITS   = 12;
   localparam int FIRST_BITS  = 7;
   localparam int STEP_BITS   = 8;
   localparam int ROM_DEPTH   = 256;
   localparam int PROD_BITS   = AMP_BITS + FACT_BITS;

   // per-ms decay factors in Q0.32: exp(-1/220) and exp(-1/550)
   localparam logic [63:0] REL_Q32      = 64'd4275489020;
   localparam logic [63:0] PEAK_REL_Q32 = 64'd4287165359;

   localparam logic [HOLD_BITS-1:0]  HOLD_TIME_RESET  = HOLD_BITS'(650);
   localparam logic [FIRST_BITS-1:0] FIRST_STEP_RESET = FIRST_BITS'(16);
   localparam logic [STEP_BITS-1:0]  STEP_MAX         = STEP_BITS'(MAX_STEP_MS);

   // configuration register indexes
   localparam logic CSR_HOLD_TIME  = 1'b0;
   localparam logic CSR_FIRST_STEP = 1'b1;

   typedef logic [AMP_BITS-1:0]  amp_type;
   typedef logic [HOLD_BITS-1:0] hold_type;
   typedef logic [STEP_BITS-1:0] step_type;
   typedef logic [FACT_BITS-1:0] fact_type;
   typedef logic [ROM_DEPTH-1:0][FACT_BITS-1:0] rom_type;

   typedef struct packed {
      amp_type                left_amplitude;
      amp_type                right_amplitude;
      logic [STEP_BITS-1:0]   elapsed_ms;
      logic                   clear;
   } req_type;

   typedef struct packed {
      amp_type left_level;
      amp_type right_level;
      amp_type left_peak_hold;
      amp_type right_peak_hold;
   } rsp_type;

   typedef struct packed {
      amp_type  level;
      amp_type  peak;
      hold_type hold;
   } chan_type;

   // Elaboration-time build of a factor table: r^t in Q0.32, rounded to Q0.16.
   function automatic rom_type build_rom(logic [63:0] r);
      rom_type     rom;
      logic [63:0] a;
      logic [63:0] q;
      rom    = '0;
      rom[0] = '1;
      a      = r;
      for (int t = 1; t < ROM_DEPTH; t++) begin
         q = (a + 64'd32768) >> 16;
         rom[t] = (q > 64'd65535) ? 16'hFFFF : q[FACT_BITS-1:0];
         a = ((a * r) + 64'h8000_0000) >> 32;
      end
      return rom;
   endfunction

   localparam rom_type REL_ROM  = build_rom(REL_Q32);
   localparam rom_type PEAK_ROM = build_rom(PEAK_REL_Q32);

   function automatic step_type clamp_step(step_type t);
      step_type r;
      if (t == '0) r = STEP_BITS'(1);
      else if (t > STEP_MAX) r = STEP_MAX;
      else r = t;
      return r;
   endfunction

   // One channel: instant attack, exponential release, peak hold with countdown.
   function automatic chan_type chan_update(amp_type amp, step_type t, chan_type cur,
                                            hold_type hold_time);
      chan_type                 nxt;
      logic [PROD_BITS-1:0]     lprod;
      logic [PROD_BITS-1:0]     pprod;
      hold_type                 hold_dec;
      lprod = PROD_BITS'(cur.level) * PROD_BITS'(REL_ROM[t]);
      pprod = PROD_BITS'(cur.peak) * PROD_BITS'(PEAK_ROM[t]);
      hold_dec = (cur.hold > HOLD_BITS'(t)) ? (cur.hold - HOLD_BITS'(t)) : '0;
      nxt.level = (amp >= cur.level) ? amp : lprod[PROD_BITS-1:FACT_BITS];
      if (amp >= cur.peak) begin
         nxt.peak = amp;
         nxt.hold = hold_time;
      end else begin
         nxt.hold = hold_dec;
         nxt.peak = (hold_dec == '0) ? pprod[PROD_BITS-1:FACT_BITS] : cur.peak;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/stereo_peak_meter_ballistics.sv
// A result is registered in the result register when its item is accepted, or in the skid while rsp stalls.
// Throughput: one item per cycle while req_stall is low; the state update is a single registered pass
// with one 16x16 multiply per level and per peak, from the elapsed-ms factor ROMs.
// A two-entry output stage (result register plus skid) lets input flow while rsp stalls.
// Reset (synchronous) zeroes levels, peaks, hold counters and the first-item flag,
// and loads hold time 650 ms and first step 16 ms. Depends on spm_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stereo_peak_meter_ballistics
   import spm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [HOLD_BITS-1:0]  csr_wdata
);

   hold_type               hold_time_ff;
   logic [FIRST_BITS-1:0]  first_step_ff;
   chan_type               left_ff, left_in;
   chan_type               right_ff, right_in;
   logic                   seen_first_ff, seen_first_in;
   rsp_type                out_ff, skid_ff, result;
   logic                   out_valid_ff, skid_valid_ff;
   logic                   req_accept, out_free;
   step_type               step;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_payload = out_ff;

   assign step = seen_first_ff ? clamp_step(req_payload.elapsed_ms)
                               : clamp_step({1'b0, first_step_ff});

   always_comb begin
      left_in       = left_ff;
      right_in      = right_ff;
      seen_first_in = seen_first_ff;
      if (req_accept) begin
         if (req_payload.clear) begin
            left_in  = '0;
            right_in = '0;
         end else begin
            left_in  = chan_update(req_payload.left_amplitude, step, left_ff, hold_time_ff);
            right_in = chan_update(req_payload.right_amplitude, step, right_ff, hold_time_ff);
            seen_first_in = 1'b1;
         end
      end
   end

   assign result.left_level      = left_in.level;
   assign result.right_level     = right_in.level;
   assign result.left_peak_hold  = left_in.peak;
   assign result.right_peak_hold = right_in.peak;

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_time_ff  <= HOLD_TIME_RESET;
         first_step_ff <= FIRST_STEP_RESET;
         left_ff       <= '0;
         right_ff      <= '0;
         seen_first_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_HOLD_TIME:  hold_time_ff  <= csr_wdata;
               CSR_FIRST_STEP: first_step_ff <= csr_wdata[FIRST_BITS-1:0];
               default:        hold_time_ff  <= hold_time_ff;
            endcase
         end
         left_ff       <= left_in;
         right_ff      <= right_in;
         seen_first_ff <= seen_first_in;
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= req_accept;
            end
         end else if (req_accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_accept) begin
            out_ff <= result;
         end
      end else if (req_accept) begin
         skid_ff <= result;
      end
   end

   `ASSERT_AT(a_skid_needs_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid full while result register empty")
   `ASSERT_NEXT(a_stalled_accept_to_skid, clock, reset, req_accept && !out_free, skid_valid_ff, "item accepted under stall was not parked in skid")
   `ASSERT_NEXT(a_clear_zeroes, clock, reset, req_accept && req_payload.clear, left_ff == '0 && right_ff == '0, "clear item left state nonzero")
   `ASSERT_NEXT(a_first_seen, clock, reset, req_accept && !req_payload.clear, seen_first_ff, "first-item flag not set after update")

endmodule

`default_nettype wire

FILE: sim/spm_meter_checker.sv
`timescale 1ns / 1ps
// Checker for the stereo peak meter: predicts each reading from the accepted items
// and compares it with the accepted results. Depends on spm_pkg.
module spm_meter_checker
   import spm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire req_type              req_payload,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsp_type              rsp_payload,
   input  wire logic                 csr_we,
   input  wire logic                 csr_index,
   input  wire logic [HOLD_BITS-1:0] csr_wdata,
   output int                        mismatches,
   output int                        pending
);

   typedef bit [15:0] factor_table_type [0:255];

   typedef struct {
      amp_type  level;
      amp_type  peak;
      hold_type hold;
   } meter_state_type;

   factor_table_type release_factors;
   factor_table_type peak_factors;
   meter_state_type  left_meter;
   meter_state_type  right_meter;
   logic [11:0]      hold_time_cfg;
   logic [6:0]       first_step_cfg;
   bit               seen_first;
   int               miss_count;
   rsp_type          expected_readings[$];

   // r^t in Q0.32 by repeated rounded multiply, then rounded to Q0.16
   function automatic factor_table_type power_table(longint unsigned per_ms);
      factor_table_type tab;
      longint unsigned  acc;
      longint unsigned  rounded;
      tab[0] = 16'hFFFF;
      acc = per_ms;
      for (int t = 1; t < 256; t++) begin
         rounded = (acc + 64'd32768) >> 16;
         tab[t] = (rounded > 64'd65535) ? 16'hFFFF : rounded[15:0];
         acc = (acc * per_ms + 64'h8000_0000) >> 32;
      end
      return tab;
   endfunction

   function automatic int unsigned bound_step(int unsigned ms);
      if (ms < 1) return 1;
      if (ms > MAX_STEP_MS) return MAX_STEP_MS;
      return ms;
   endfunction

   function automatic amp_type scale(amp_type v, bit [15:0] f);
      logic [31:0] prod;
      prod = 32'(v) * 32'(f);
      return prod[31:16];
   endfunction

   function automatic meter_state_type meter_advance(amp_type amp, int unsigned t,
                                                     meter_state_type cur);
      meter_state_type nxt;
      nxt = cur;
      nxt.level = (amp >= cur.level) ? amp : scale(cur.level, release_factors[t]);
      if (amp >= cur.peak) begin
         nxt.peak = amp;
         nxt.hold = hold_time_cfg;
      end else begin
         nxt.hold = (cur.hold > t) ? hold_type'(cur.hold - t) : '0;
         if (nxt.hold == '0) nxt.peak = scale(cur.peak, peak_factors[t]);
      end
      return nxt;
   endfunction

   function automatic rsp_type predict_reading(req_type it);
      rsp_type     r;
      int unsigned t;
      if (it.clear) begin
         // clear does not count as the first item
         left_meter  = '{default: '0};
         right_meter = '{default: '0};
      end else begin
         t = seen_first ? bound_step(it.elapsed_ms) : bound_step(first_step_cfg);
         seen_first = 1'b1;
         left_meter  = meter_advance(it.left_amplitude, t, left_meter);
         right_meter = meter_advance(it.right_amplitude, t, right_meter);
      end
      r.left_level      = left_meter.level;
      r.right_level     = right_meter.level;
      r.left_peak_hold  = left_meter.peak;
      r.right_peak_hold = right_meter.peak;
      return r;
   endfunction

   function automatic void report_miss(string why, rsp_type want);
      miss_count++;
      if (miss_count <= 10) begin
         $display("%0t %s: exp ll=%h rl=%h lp=%h rp=%h  got ll=%h rl=%h lp=%h rp=%h",
                  $time, why, want.left_level, want.right_level, want.left_peak_hold,
                  want.right_peak_hold, rsp_payload.left_level, rsp_payload.right_level,
                  rsp_payload.left_peak_hold, rsp_payload.right_peak_hold);
      end
   endfunction

   initial begin
      release_factors = power_table(REL_Q32);
      peak_factors    = power_table(PEAK_REL_Q32);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         left_meter     = '{default: '0};
         right_meter    = '{default: '0};
         hold_time_cfg  = 12'd650;
         first_step_cfg = 7'd16;
         seen_first     = 1'b0;
         miss_count     = 0;
         expected_readings.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_HOLD_TIME) hold_time_cfg = csr_wdata;
            else first_step_cfg = csr_wdata[6:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               report_miss("unexpected item", '0);
            end else begin
               want = expected_readings.pop_front();
               if (want.left_level !== rsp_payload.left_level ||
                   want.right_level !== rsp_payload.right_level ||
                   want.left_peak_hold !== rsp_payload.left_peak_hold ||
                   want.right_peak_hold !== rsp_payload.right_peak_hold)
                  report_miss("mismatch", want);
            end
         end
         if (req_valid && !req_stall) expected_readings.push_back(predict_reading(req_payload));
      end
      mismatches <= miss_count;
      pending    <= expected_readings.size();
   end

endmodule

FILE: sim/stereo_peak_meter_ballistics_test.sv
`timescale 1ns / 1ps
// Testbench top for stereo_peak_meter_ballistics: directed and shaped random items,
// random idling on both sides, register phases. Depends on spm_pkg and spm_meter_checker.
module stereo_peak_meter_ballistics_test;
   import spm_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_payload;
   logic                 csr_we;
   logic                 csr_index;
   logic [HOLD_BITS-1:0] csr_wdata;

   int      mismatches;
   int      pending;
   int      hold_off_requests;
   logic    rx_idle_on;
   bit      tx_idle_on;
   amp_type env_left, env_right;
   int      tail_left, tail_right;

   stereo_peak_meter_ballistics dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   spm_meter_checker meter_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic req_type mk_req(amp_type l, amp_type r, logic [7:0] ms, logic clr);
      req_type it;
      it.left_amplitude  = l;
      it.right_amplitude = r;
      it.elapsed_ms      = ms;
      it.clear           = clr;
      return it;
   endfunction

   task automatic send(req_type it);
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and wait for every outstanding reading
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [HOLD_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // transient followed by a tail of quieter items, so holds run out and peaks decay
   task automatic shaped_amp(inout amp_type env, inout int tail, output amp_type a);
      if (tail == 0) begin
         tail = $urandom_range(3, 80);
         env  = ($urandom_range(0, 7) == 0) ? 16'hFFFF : amp_type'($urandom);
         a    = env;
      end else begin
         tail--;
         case ($urandom_range(0, 7))
            0:       a = env;
            1, 2, 3: a = '0;
            default: a = amp_type'($urandom_range(0, env >> $urandom_range(1, 6)));
         endcase
      end
   endtask

   task automatic next_item(output req_type it);
      int roll;
      int pick;
      roll = $urandom_range(0, 99);
      it = req_type'({$urandom, $urandom});
      if (roll < 2) begin
         it.clear = 1'b1;
      end else if (roll >= 12) begin
         it.clear = 1'b0;
         shaped_amp(env_left, tail_left, it.left_amplitude);
         shaped_amp(env_right, tail_right, it.right_amplitude);
         pick = $urandom_range(0, 15);
         if (pick == 0) it.elapsed_ms = '0;
         else if (pick == 1) it.elapsed_ms = 8'($urandom_range(101, 255));
         else if (pick < 8) it.elapsed_ms = 8'($urandom_range(1, 20));
         else it.elapsed_ms = 8'($urandom_range(1, 100));
      end
   endtask

   // receiver: random stall bursts, plus a long hold-off on request
   initial begin
      int served;
      served = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_off_requests) begin
            served = hold_off_requests;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #3_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_type              it;
      logic [HOLD_BITS-1:0] phase_hold [7];
      logic [HOLD_BITS-1:0] phase_first [7];
      logic [HOLD_BITS-1:0] first_pre;

      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_payload       <= '0;
      csr_we            <= 1'b0;
      csr_index         <= CSR_HOLD_TIME;
      csr_wdata         <= '0;
      hold_off_requests <= 0;
      rx_idle_on        <= 1'b1;
      tx_idle_on = 1'b1;
      env_left   = '0;
      env_right  = '0;
      tail_left  = 0;
      tail_right = 0;

      phase_hold  = '{12'd0, 12'd4095, 12'd650, 12'd1, 12'($urandom), 12'd300,
                      12'($urandom_range(0, 800))};
      phase_first = '{12'd1, 12'd100, 12'd0, 12'hFFF, 12'($urandom_range(0, 127)), 12'd16,
                      12'($urandom)};
      case ($urandom_range(0, 3))
         0:       first_pre = 12'd0;
         1:       first_pre = 12'd127;
         default: first_pre = 12'($urandom_range(1, 100));
      endcase

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first step is only used once per reset, so set it before any item
      write_reg(CSR_HOLD_TIME, 12'd5);
      write_reg(CSR_FIRST_STEP, first_pre);
      csr_we <= 1'b0;

      send(mk_req(16'h1234, 16'h5678, 8'd7, 1'b1));
      send(mk_req(16'hFFFF, 16'h0000, 8'd0, 1'b0));
      send(mk_req(16'hFFFF, 16'hFFFF, 8'd0, 1'b0));
      send(mk_req(16'h0000, 16'h0000, 8'd0, 1'b0));
      send(mk_req(16'h0000, 16'h0000, 8'd255, 1'b0));
      send(mk_req(16'h0000, 16'h0000, 8'd101, 1'b0));
      send(mk_req(16'h0000, 16'h0000, 8'd100, 1'b0));
      send(mk_req(16'h0000, 16'h0000, 8'd1, 1'b0));
      send(mk_req(16'h8000, 16'h7FFF, 8'd50, 1'b0));
      send(mk_req(16'h7FFF, 16'h8000, 8'd50, 1'b0));
      send(mk_req(16'h7FFF, 16'h8000, 8'd50, 1'b0));
      send(mk_req(16'hAAAA, 16'h5555, 8'd255, 1'b0));
      send(mk_req(16'h5555, 16'hAAAA, 8'd0, 1'b0));
      send(mk_req(16'h0001, 16'h0000, 8'd1, 1'b0));
      send(mk_req(16'hFFFF, 16'hFFFF, 8'd255, 1'b1));
      send(mk_req(16'h0000, 16'h0000, 8'd0, 1'b0));
      send(mk_req(16'h0001, 16'h0001, 8'd100, 1'b0));
      repeat (6) send(mk_req(16'h0000, 16'h0000, 8'd100, 1'b0));

      for (int p = 0; p < 7; p++) begin
         settle();
         write_reg(CSR_HOLD_TIME, phase_hold[p]);
         write_reg(CSR_FIRST_STEP, phase_first[p]);
         csr_we <= 1'b0;
         // last phase runs without idling on either side
         tx_idle_on = (p != 6);
         rx_idle_on <= (p != 6);
         for (int n = 0; n < 200; n++) begin
            if (p == 2 && n == 60) hold_off_requests <= hold_off_requests + 1;
            next_item(it);
            send(it);
            if (tx_idle_on && $urandom_range(0, 9) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 17)) @(posedge clock);
            end
         end
      end

      settle();
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
